// ----- rtl/core/tvdlf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvdlf_pkg
// Shared types and constants of the limited face value pipeline.
// ----------------------------------------------------------------------------
package tvdlf_pkg;

	// scheme select codes
	localparam logic [1:0] MODE_UPWIND = 2'd0;
	localparam logic [1:0] MODE_LINEAR = 2'd1;
	localparam logic [1:0] MODE_QUICK  = 2'd2;

	// divider geometry: 32 x 63 bit numerator, 33 x 32 bit denominator
	localparam int DIV_NW = 95;
	localparam int DIV_DW = 65;
	localparam int DIV_QB = 41;
	localparam int DIV_LAT = DIV_QB + 1;

	// cap on one quick term magnitude
	localparam logic [DIV_QB-1:0] TERM_CAP = DIV_QB'(1) << 40;

	// fields riding alongside the dividers
	typedef struct packed {
		logic signed [31:0] up;
		logic signed [31:0] down;
		logic signed [31:0] high_lin;
		logic               lin;
		logic               uq;
		logic               lim;
		logic               err;
		logic               psi_ok;
		logic               neg_c;
		logic               neg_u;
		logic               neg_d;
	} side_t;

	// saturate a wide signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > 66'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -66'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/tvd_limited_face_value_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvd_limited_face_value_top
// Van Leer limited upwind / linear upwind / QUICK face value, fully pipelined.
// ----------------------------------------------------------------------------
// channel   | handshake             | word
// stencil   | start (busy low)      | phi_far .. offset_y
// config    | cfg_valid & cfg_ready | cfg_data = scheme mode
// result    | done strobe           | face_value, limiter_weight, spacing_error
//
// one stencil accepted per cycle, busy never rises
// result strobes once the stencil has passed 4 front stages, the 42-stage
//   divider pipelines (entry plus one quotient bit each) and 3 back stages
// reset clears valid bits and the mode register; datapath has no reset
// the receiver cannot stall, so the pipeline never holds
// ----------------------------------------------------------------------------
module tvd_limited_face_value_top
	import tvdlf_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] phi_far,
	input  logic signed [31:0] phi_up,
	input  logic signed [31:0] phi_down,
	input  logic               far_available,
	input  logic [30:0]        far_spacing,
	input  logic [30:0]        up_to_face,
	input  logic [30:0]        face_to_down,
	input  logic signed [31:0] grad_x,
	input  logic signed [31:0] grad_y,
	input  logic signed [31:0] offset_x,
	input  logic signed [31:0] offset_y,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_data,
	output logic               done,
	output logic signed [31:0] face_value,
	output logic [17:0]        limiter_weight,
	output logic               spacing_error
);

	localparam int PSIW = FRAC_BITS + 2;
	localparam int PW = PSIW + 34;

	logic [1:0] mode_q;

	// mode register, always writable
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_UPWIND;
		end else if (cfg_valid) begin
			mode_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;
	assign busy = 1'b0;

	// valid chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic vd_q [0:DIV_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			for (int i = 0; i < DIV_LAT; i++) begin
				vd_q[i] <= 1'b0;
			end
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			vd_q[0] <= v_s4;
			for (int i = 1; i < DIV_LAT; i++) begin
				vd_q[i] <= vd_q[i-1];
			end
			v_s5 <= vd_q[DIV_LAT-1];
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// stage 1: capture word, spacing sums
	logic signed [31:0] far_s1, up_s1, down_s1, gx_s1, gy_s1, ox_s1, oy_s1;
	logic [30:0] a_s1, u_s1, d_s1;
	logic [32:0] s_s1;
	logic [31:0] t_s1, p_s1;
	logic avail_s1, lin_s1, quick_s1;

	always_ff @(posedge clk) begin
		far_s1   <= phi_far;
		up_s1    <= phi_up;
		down_s1  <= phi_down;
		gx_s1    <= grad_x;
		gy_s1    <= grad_y;
		ox_s1    <= offset_x;
		oy_s1    <= offset_y;
		a_s1     <= far_spacing;
		u_s1     <= up_to_face;
		d_s1     <= face_to_down;
		avail_s1 <= far_available;
		lin_s1   <= mode_q == MODE_LINEAR;
		quick_s1 <= mode_q == MODE_QUICK;
		s_s1     <= 33'(far_spacing) + 33'(up_to_face) + 33'(face_to_down);
		t_s1     <= 32'(up_to_face) + 32'(face_to_down);
		p_s1     <= 32'(up_to_face) + 32'(far_spacing);
	end

	// stage 2: weight products, magnitudes, limiter preconditions
	logic signed [32:0] da, db;
	logic err1, lim1;
	logic [62:0] numc_s2, numu_s2, numd_s2;
	logic [64:0] denc_s2, denu_s2, dend_s2;
	logic [31:0] magc_s2, magu_s2, magd_s2, ua_s2, ub_s2;
	logic signed [63:0] pgx_s2, pgy_s2;
	logic signed [31:0] up_s2, down_s2;
	logic negc_s2, negu_s2, negd_s2, psiok_s2, err_s2, lim_s2, uq_s2, lin_s2;

	assign da = 33'(up_s1) - 33'(far_s1);
	assign db = 33'(down_s1) - 33'(up_s1);
	assign err1 = quick_s1 && avail_s1 && (a_s1 == '0 || u_s1 == '0 || d_s1 == '0);
	assign lim1 = lin_s1 || (quick_s1 && !err1);

	always_ff @(posedge clk) begin
		numc_s2  <= 63'(u_s1) * 63'(d_s1);
		numu_s2  <= 63'(p_s1) * 63'(d_s1);
		numd_s2  <= 63'(u_s1) * 63'(p_s1);
		denc_s2  <= 65'(a_s1) * 65'(s_s1);
		denu_s2  <= 65'(a_s1) * 65'(t_s1);
		dend_s2  <= 65'(s_s1) * 65'(t_s1);
		magc_s2  <= far_s1[31] ? (~far_s1 + 32'd1) : far_s1;
		magu_s2  <= up_s1[31] ? (~up_s1 + 32'd1) : up_s1;
		magd_s2  <= down_s1[31] ? (~down_s1 + 32'd1) : down_s1;
		negc_s2  <= ~far_s1[31];
		negu_s2  <= up_s1[31];
		negd_s2  <= down_s1[31];
		ua_s2    <= da[32] ? 32'(-da) : da[31:0];
		ub_s2    <= db[32] ? 32'(-db) : db[31:0];
		psiok_s2 <= lim1 && avail_s1 && da != '0 && db != '0 && da[32] == db[32];
		pgx_s2   <= gx_s1 * ox_s1;
		pgy_s2   <= gy_s1 * oy_s1;
		up_s2    <= up_s1;
		down_s2  <= down_s1;
		err_s2   <= err1;
		lim_s2   <= lim1;
		uq_s2    <= quick_s1 && avail_s1 && !err1;
		lin_s2   <= lin_s1;
	end

	// stage 3: split phi x weight products, linear upwind value
	logic [63:0] plc_s3, plu_s3, pld_s3;
	logic [62:0] phc_s3, phu_s3, phd_s3;
	logic [64:0] denc_s3, denu_s3, dend_s3;
	logic [31:0] ua_s3, ub_s3;
	logic signed [31:0] hlin_s3, up_s3, down_s3;
	logic negc_s3, negu_s3, negd_s3, psiok_s3, err_s3, lim_s3, uq_s3, lin_s3;
	logic signed [65:0] lin_sum;

	assign lin_sum = 66'(up_s2) + 66'(pgx_s2 >>> FRAC_BITS) + 66'(pgy_s2 >>> FRAC_BITS);

	always_ff @(posedge clk) begin
		plc_s3   <= 64'(magc_s2) * 64'(numc_s2[31:0]);
		plu_s3   <= 64'(magu_s2) * 64'(numu_s2[31:0]);
		pld_s3   <= 64'(magd_s2) * 64'(numd_s2[31:0]);
		phc_s3   <= 63'(magc_s2) * 63'(numc_s2[62:32]);
		phu_s3   <= 63'(magu_s2) * 63'(numu_s2[62:32]);
		phd_s3   <= 63'(magd_s2) * 63'(numd_s2[62:32]);
		hlin_s3  <= sat32(lin_sum);
		denc_s3  <= denc_s2;
		denu_s3  <= denu_s2;
		dend_s3  <= dend_s2;
		ua_s3    <= ua_s2;
		ub_s3    <= ub_s2;
		up_s3    <= up_s2;
		down_s3  <= down_s2;
		negc_s3  <= negc_s2;
		negu_s3  <= negu_s2;
		negd_s3  <= negd_s2;
		psiok_s3 <= psiok_s2;
		err_s3   <= err_s2;
		lim_s3   <= lim_s2;
		uq_s3    <= uq_s2;
		lin_s3   <= lin_s2;
	end

	// stage 4: assemble divider operands
	logic [DIV_NW-1:0] nc_s4, nu_s4, nd_s4, npsi_s4;
	logic [DIV_DW-1:0] dc_s4, du_s4, dd_s4, dpsi_s4;
	side_t side_s4;

	always_ff @(posedge clk) begin
		nc_s4   <= DIV_NW'(plc_s3) + (DIV_NW'(phc_s3) << 32);
		nu_s4   <= DIV_NW'(plu_s3) + (DIV_NW'(phu_s3) << 32);
		nd_s4   <= DIV_NW'(pld_s3) + (DIV_NW'(phd_s3) << 32);
		npsi_s4 <= DIV_NW'(ua_s3) << (FRAC_BITS + 1);
		dc_s4   <= denc_s3;
		du_s4   <= denu_s3;
		dd_s4   <= dend_s3;
		dpsi_s4 <= DIV_DW'(ua_s3) + DIV_DW'(ub_s3);
		side_s4 <= '{up: up_s3, down: down_s3, high_lin: hlin_s3, lin: lin_s3, uq: uq_s3,
			lim: lim_s3, err: err_s3, psi_ok: psiok_s3, neg_c: negc_s3,
			neg_u: negu_s3, neg_d: negd_s3};
	end

	// dividers for the three lagrange terms and the smoothness ratio
	logic [DIV_QB-1:0] qc, qu, qd, qpsi;
	logic oc, ou, od, opsi;

	tvdlf_div #(.NW(DIV_NW), .DW(DIV_DW), .QB(DIV_QB)) u_div_c (
		.clk(clk), .num(nc_s4), .den(dc_s4), .quo(qc), .ovf(oc));
	tvdlf_div #(.NW(DIV_NW), .DW(DIV_DW), .QB(DIV_QB)) u_div_u (
		.clk(clk), .num(nu_s4), .den(du_s4), .quo(qu), .ovf(ou));
	tvdlf_div #(.NW(DIV_NW), .DW(DIV_DW), .QB(DIV_QB)) u_div_d (
		.clk(clk), .num(nd_s4), .den(dd_s4), .quo(qd), .ovf(od));
	tvdlf_div #(.NW(DIV_NW), .DW(DIV_DW), .QB(DIV_QB)) u_div_psi (
		.clk(clk), .num(npsi_s4), .den(dpsi_s4), .quo(qpsi), .ovf(opsi));

	// side fields follow the divider latency
	side_t side_q [0:DIV_LAT-1];

	always_ff @(posedge clk) begin
		side_q[0] <= side_s4;
		for (int i = 1; i < DIV_LAT; i++) begin
			side_q[i] <= side_q[i-1];
		end
	end

	// stage 5: cap and sign terms, pick high-order value and psi
	side_t sd;
	logic [DIV_QB-1:0] mc, mu, md;
	logic signed [42:0] tc, tu, td, qsum;
	logic signed [31:0] high_s5, up_s5, down_s5;
	logic [PSIW-1:0] psi_s5;
	logic lim_s5, err_s5;

	assign sd = side_q[DIV_LAT-1];
	assign mc = (oc || qc > TERM_CAP) ? TERM_CAP : qc;
	assign mu = (ou || qu > TERM_CAP) ? TERM_CAP : qu;
	assign md = (od || qd > TERM_CAP) ? TERM_CAP : qd;
	assign tc = sd.neg_c ? -43'(mc) : 43'(mc);
	assign tu = sd.neg_u ? -43'(mu) : 43'(mu);
	assign td = sd.neg_d ? -43'(md) : 43'(md);
	assign qsum = tc + tu + td;

	always_ff @(posedge clk) begin
		if (sd.lin) begin
			high_s5 <= sd.high_lin;
		end else if (sd.uq) begin
			high_s5 <= sat32(66'(qsum));
		end else begin
			high_s5 <= sd.up;
		end
		psi_s5  <= (sd.psi_ok && !opsi) ? qpsi[PSIW-1:0] : '0;
		up_s5   <= sd.up;
		down_s5 <= sd.down;
		lim_s5  <= sd.lim;
		err_s5  <= sd.err;
	end

	// stage 6: psi times high-order correction
	logic signed [32:0] diff;
	logic signed [PW-1:0] prod_s6;
	logic signed [31:0] up_s6, down_s6;
	logic [PSIW-1:0] psi_s6;
	logic lim_s6, err_s6;

	assign diff = 33'(high_s5) - 33'(up_s5);

	always_ff @(posedge clk) begin
		prod_s6 <= $signed({1'b0, psi_s5}) * PW'(diff);
		up_s6   <= up_s5;
		down_s6 <= down_s5;
		psi_s6  <= psi_s5;
		lim_s6  <= lim_s5;
		err_s6  <= err_s5;
	end

	// stage 7: blend, clamp between upwind and downwind, output word
	logic signed [PW:0] blend, lo_v, hi_v;

	assign blend = (PW+1)'(up_s6) + (PW+1)'(prod_s6 >>> FRAC_BITS);
	assign lo_v = (up_s6 < down_s6) ? (PW+1)'(up_s6) : (PW+1)'(down_s6);
	assign hi_v = (up_s6 < down_s6) ? (PW+1)'(down_s6) : (PW+1)'(up_s6);

	always_ff @(posedge clk) begin
		if (!lim_s6) begin
			face_value <= up_s6;
		end else if (blend < lo_v) begin
			face_value <= lo_v[31:0];
		end else if (blend > hi_v) begin
			face_value <= hi_v[31:0];
		end else begin
			face_value <= blend[31:0];
		end
		limiter_weight <= (PSIW'(psi_s6) > PSIW'(18'h3FFFF)) ? 18'h3FFFF : 18'(psi_s6);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_error <= 1'b0;
		end else begin
			spacing_error <= v_s6 && err_s6;
		end
	end

	assign done = v_s7;

`ifndef SYNTH
	// a spacing error never carries a limiter weight
	a_err_no_psi: assert property (@(posedge clk) disable iff (!arst_n)
		spacing_error |-> limiter_weight == '0)
		else $error("spacing error with nonzero limiter weight");

	// error flag only rides on a result
	a_err_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		spacing_error |-> done)
		else $error("spacing error without result strobe");

	// van leer weight stays below two
	a_psi_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> 32'(limiter_weight) < (32'd1 << (FRAC_BITS + 1)))
		else $error("limiter weight out of range");
`endif

endmodule

// ----- rtl/core/tvdlf_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvdlf_div
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
module tvdlf_div
	import tvdlf_pkg::*;
#(
	parameter int NW = 95,
	parameter int DW = 65,
	parameter int QB = 41
) (
	input  logic          clk,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QB-1:0] quo,
	output logic          ovf
);

	localparam int CW = (NW > DW + QB) ? NW : DW + QB;

	logic [NW-1:0] rem_q [0:QB];
	logic [DW-1:0] den_q [0:QB];
	logic [QB-1:0] quo_q [0:QB];
	logic          ovf_q [0:QB];

	// entry: flag quotients that do not fit the quotient width
	always_ff @(posedge clk) begin
		rem_q[0] <= num;
		den_q[0] <= den;
		quo_q[0] <= '0;
		ovf_q[0] <= (CW'(den) << QB) <= CW'(num);
	end

	// one compare and subtract per stage
	for (genvar k = 0; k < QB; k++) begin : g_step
		localparam int SH = QB - 1 - k;
		logic [CW-1:0] shd;
		logic          fit;
		assign shd = CW'(den_q[k]) << SH;
		assign fit = CW'(rem_q[k]) >= shd;
		always_ff @(posedge clk) begin
			rem_q[k+1] <= fit ? NW'(CW'(rem_q[k]) - shd) : rem_q[k];
			den_q[k+1] <= den_q[k];
			quo_q[k+1] <= quo_q[k] | (fit ? (QB'(1) << SH) : '0);
			ovf_q[k+1] <= ovf_q[k];
		end
	end

	assign quo = quo_q[QB];
	assign ovf = ovf_q[QB];

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the limited face value pipeline. A directed table
// covers reset state, every scheme, missing far cell, zero quick spacing and
// value extremes; random stencils in several scheme settings follow. Each
// accepted stencil gets its expected word from the table or from face_predict
// and is compared with the strobed result word in order.
// ----------------------------------------------------------------------------
module tb;
	import tvdlf_pkg::*;

	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int LATENCY = 49;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 1430;
	localparam logic [127:0] QUICK_CAP = 128'd1 << 40;

	typedef struct {
		logic signed [31:0] far, up, down;
		logic               avail;
		logic [30:0]        sp_far, sp_up, sp_down;
		logic signed [31:0] gx, gy, ox, oy;
	} stencil_t;

	typedef struct {
		logic signed [31:0] face;
		logic [17:0]        weight;
		logic               err;
	} face_result_t;

	typedef struct {
		logic [1:0]   mode;
		stencil_t     s;
		logic         typed;
		face_result_t res;
	} table_row_t;

	logic               clk, arst_n, start, busy;
	logic signed [31:0] phi_far, phi_up, phi_down;
	logic               far_available;
	logic [30:0]        far_spacing, up_to_face, face_to_down;
	logic signed [31:0] grad_x, grad_y, offset_x, offset_y;
	logic               cfg_valid, cfg_ready;
	logic [1:0]         cfg_data;
	logic               done;
	logic signed [31:0] face_value;
	logic [17:0]        limiter_weight;
	logic               spacing_error;

	face_result_t face_expected[$];
	logic [1:0]   scheme;
	int           mismatches = 0;
	int           results_seen = 0;
	int           items_sent = 0;
	int           quick_errors = 0;
	int           cycles = 0;

	tvd_limited_face_value_top i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.phi_far(phi_far), .phi_up(phi_up), .phi_down(phi_down),
		.far_available(far_available), .far_spacing(far_spacing),
		.up_to_face(up_to_face), .face_to_down(face_to_down),
		.grad_x(grad_x), .grad_y(grad_y), .offset_x(offset_x), .offset_y(offset_y),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .face_value(face_value), .limiter_weight(limiter_weight),
		.spacing_error(spacing_error)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tvd_limited_face_value_top: mismatch");
			$finish;
		end
	end

	function automatic logic signed [63:0] sat_word(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// one lagrange term phi * num / den, truncated toward zero and capped
	function automatic logic signed [63:0] lagrange_term(input logic signed [63:0] phi,
			input logic [63:0] num, input logic [127:0] den, input logic neg);
		logic [63:0]  mag;
		logic [127:0] prod, q;
		logic signed [63:0] t;
		mag = (phi < 0) ? -phi : phi;
		prod = {64'd0, mag} * {64'd0, num};
		q = prod / den;
		if (q > QUICK_CAP) q = QUICK_CAP;
		t = q[63:0];
		return ((phi < 0) != neg) ? -t : t;
	endfunction

	// expected face value, limiter weight and error flag for one stencil
	function automatic face_result_t face_predict(input logic [1:0] mode, input stencil_t s);
		face_result_t r;
		logic signed [63:0] far, up, down, high, a, b, blend, lo, hi, sum;
		logic [63:0] ua, ub, psi, ca, cu, cd, ss, tt, pp;
		far = s.far;
		up = s.up;
		down = s.down;
		high = up;
		psi = 0;
		r.face = s.up;
		r.err = 1'b0;
		if (mode == MODE_LINEAR || mode == MODE_QUICK) begin
			if (mode == MODE_LINEAR) begin
				high = sat_word(up + ((64'(s.gx) * 64'(s.ox)) >>> 16)
					+ ((64'(s.gy) * 64'(s.oy)) >>> 16));
			end else if (s.avail) begin
				if (s.sp_far == 0 || s.sp_up == 0 || s.sp_down == 0) begin
					r.err = 1'b1;
				end else begin
					ca = 64'(s.sp_far);
					cu = 64'(s.sp_up);
					cd = 64'(s.sp_down);
					ss = cu + ca + cd;
					tt = cu + cd;
					pp = cu + ca;
					sum = lagrange_term(far, cu * cd, {64'd0, ca} * {64'd0, ss}, 1'b1)
						+ lagrange_term(up, pp * cd, {64'd0, ca} * {64'd0, tt}, 1'b0)
						+ lagrange_term(down, cu * pp, {64'd0, ss} * {64'd0, tt}, 1'b0);
					high = sat_word(sum);
				end
			end
			if (!r.err) begin
				// van leer weight from the smoothness ratio
				a = up - far;
				b = down - up;
				if (s.avail && a != 0 && b != 0 && ((a > 0) == (b > 0))) begin
					ua = (a > 0) ? a : -a;
					ub = (b > 0) ? b : -b;
					psi = (ua << 17) / (ua + ub);
				end
				blend = up + (($signed(psi) * (high - up)) >>> 16);
				lo = (up < down) ? up : down;
				hi = (up < down) ? down : up;
				blend = (blend < lo) ? lo : ((blend > hi) ? hi : blend);
				r.face = blend[31:0];
			end
		end
		r.weight = (psi > 64'h3FFFF) ? 18'h3FFFF : psi[17:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: %s got %h want %h", $realtime, what, got, want);
		mismatches++;
	endtask

	// result checker
	always @(posedge clk) begin
		face_result_t w;
		if (done) begin
			results_seen++;
			if (face_expected.size() == 0) begin
				report_mismatch("unexpected word", face_value, 32'd0);
			end else begin
				w = face_expected.pop_front();
				if (face_value !== w.face) report_mismatch("face_value", face_value, w.face);
				if (limiter_weight !== w.weight)
					report_mismatch("limiter_weight", 32'(limiter_weight), 32'(w.weight));
				if (spacing_error !== w.err)
					report_mismatch("spacing_error", 32'(spacing_error), 32'(w.err));
			end
		end
	end

	task automatic drain;
		start <= 1'b0;
		while (face_expected.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_scheme(input logic [1:0] m);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		scheme = m;
	endtask

	// present one stencil and hold it until the block takes it
	task automatic put_stencil(input stencil_t s, input logic typed, input face_result_t res);
		face_result_t w;
		start <= 1'b1;
		phi_far <= s.far;
		phi_up <= s.up;
		phi_down <= s.down;
		far_available <= s.avail;
		far_spacing <= s.sp_far;
		up_to_face <= s.sp_up;
		face_to_down <= s.sp_down;
		grad_x <= s.gx;
		grad_y <= s.gy;
		offset_x <= s.ox;
		offset_y <= s.oy;
		@(posedge clk);
		while (busy) @(posedge clk);
		w = typed ? res : face_predict(scheme, s);
		if (w.err) quick_errors++;
		face_expected.push_back(w);
		items_sent++;
	endtask

	function automatic logic signed [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'sh7FFFFFFF;
			2: return 32'sh80000000;
			default: return $signed($urandom_range(0, 32'h00400000)) - 32'sh00200000;
		endcase
	endfunction

	function automatic logic [30:0] rand_spacing();
		case ($urandom_range(0, 19))
			0: return 31'd0;
			1: return 31'h7FFFFFFF;
			2, 3: return 31'($urandom);
			default: return 31'($urandom_range(1, 32'h00040000));
		endcase
	endfunction

	function automatic stencil_t rand_stencil();
		stencil_t s;
		logic signed [31:0] v[3];
		s.far = rand_value();
		s.up = rand_value();
		s.down = rand_value();
		// mostly monotone stencils so the limiter is active
		if ($urandom_range(0, 9) < 6) begin
			v[0] = s.far; v[1] = s.up; v[2] = s.down;
			v.sort();
			if ($urandom_range(0, 1)) v.reverse();
			s.far = v[0]; s.up = v[1]; s.down = v[2];
		end
		s.avail = ($urandom_range(0, 9) != 0);
		s.sp_far = rand_spacing();
		s.sp_up = rand_spacing();
		s.sp_down = rand_spacing();
		s.gx = rand_value();
		s.gy = rand_value();
		s.ox = rand_value();
		s.oy = rand_value();
		return s;
	endfunction

	// stimulus
	initial begin
		table_row_t   rows[$];
		table_row_t   row;
		stencil_t     base;
		face_result_t none;
		logic [1:0]   phase_modes[8];
		int           n;
		phase_modes = '{MODE_LINEAR, MODE_QUICK, MODE_UPWIND, MODE_QUICK,
			MODE_SPARE, MODE_LINEAR, MODE_QUICK, MODE_LINEAR};
		arst_n = 1'b0;
		start = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = MODE_UPWIND;
		{phi_far, phi_up, phi_down, grad_x, grad_y, offset_x, offset_y} = '0;
		far_available = 1'b0;
		{far_spacing, up_to_face, face_to_down} = '0;
		scheme = MODE_UPWIND;
		none = '{face: 0, weight: 0, err: 0};

		base = '{far: 32'sh00010000, up: 32'sh00020000, down: 32'sh00040000, avail: 1'b1,
			sp_far: 31'h10000, sp_up: 31'h8000, sp_down: 31'h8000,
			gx: 32'sh00010000, gy: -32'sh00008000, ox: 32'sh00008000, oy: 32'sh00004000};

		// upwind after reset, extreme values
		row = '{mode: MODE_UPWIND, s: base, typed: 1'b1, res: none};
		row.s.up = 32'sh7FFFFFFF;
		row.res.face = 32'sh7FFFFFFF;
		rows.push_back(row);
		row.s = '{far: 32'sh7FFFFFFF, up: 32'sh80000000, down: 32'sh7FFFFFFF, avail: 1'b1,
			sp_far: 31'h7FFFFFFF, sp_up: 31'h7FFFFFFF, sp_down: 31'h7FFFFFFF,
			gx: 32'sh80000000, gy: 32'sh80000000, ox: 32'sh80000000, oy: 32'sh80000000};
		row.res.face = 32'sh80000000;
		rows.push_back(row);
		// unused mode behaves as upwind
		row = '{mode: MODE_SPARE, s: base, typed: 1'b1, res: none};
		row.res.face = base.up;
		rows.push_back(row);
		// linear upwind: smooth, no far cell, opposite slopes, saturating gradient
		row = '{mode: MODE_LINEAR, s: base, typed: 1'b0, res: none};
		rows.push_back(row);
		row.s.far = base.up; row.s.down = 32'sh00030000;
		rows.push_back(row);
		row.s = base; row.s.avail = 1'b0; row.typed = 1'b1; row.res.face = base.up;
		rows.push_back(row);
		row.s = base; row.s.far = 32'sh00030000; row.res.face = base.up;
		rows.push_back(row);
		row.s = '{far: 32'sh80000000, up: 32'sh00000000, down: 32'sh7FFFFFFF, avail: 1'b1,
			sp_far: 31'h0, sp_up: 31'h0, sp_down: 31'h0,
			gx: 32'sh7FFFFFFF, gy: 32'sh7FFFFFFF, ox: 32'sh7FFFFFFF, oy: 32'sh7FFFFFFF};
		row.typed = 1'b0;
		rows.push_back(row);
		row.s.gx = 32'sh80000000; row.s.gy = 32'sh80000000; row.s.ox = 32'sh7FFFFFFF;
		row.s.oy = 32'sh7FFFFFFF; row.s.far = 32'sh7FFFFFFF; row.s.down = 32'sh80000000;
		rows.push_back(row);
		// quick: smooth, monotone with a steep far step, no far cell, each zero spacing, extremes
		row = '{mode: MODE_QUICK, s: base, typed: 1'b0, res: none};
		rows.push_back(row);
		row.s.sp_far = 31'h10000; row.s.sp_up = 31'h8000; row.s.sp_down = 31'h8000;
		row.s.far = -32'sh00050000; row.s.up = 32'sh00010000; row.s.down = 32'sh00020000;
		rows.push_back(row);
		row.s = base; row.s.avail = 1'b0; row.s.sp_far = 31'h0;
		row.typed = 1'b1; row.res.face = base.up;
		rows.push_back(row);
		row.s = base; row.s.sp_far = 31'h0; row.res.err = 1'b1;
		rows.push_back(row);
		row.s = base; row.s.sp_up = 31'h0;
		rows.push_back(row);
		row.s = base; row.s.sp_down = 31'h0;
		rows.push_back(row);
		row.s = '{far: 32'sh80000000, up: 32'sh00000001, down: 32'sh7FFFFFFF, avail: 1'b1,
			sp_far: 31'h7FFFFFFF, sp_up: 31'h1, sp_down: 31'h7FFFFFFF,
			gx: 32'sh0, gy: 32'sh0, ox: 32'sh0, oy: 32'sh0};
		row.typed = 1'b0;
		rows.push_back(row);
		row.s.sp_far = 31'h1; row.s.sp_up = 31'h7FFFFFFF; row.s.sp_down = 31'h1;
		rows.push_back(row);
		row.s.far = 32'sh7FFFFFFF; row.s.up = 32'sh00000000; row.s.down = 32'sh80000000;
		rows.push_back(row);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed table
		foreach (rows[i]) begin
			if (rows[i].mode != scheme) set_scheme(rows[i].mode);
			put_stencil(rows[i].s, rows[i].typed, rows[i].res);
		end

		// random phases across the scheme settings
		n = 0;
		foreach (phase_modes[p]) begin
			set_scheme(phase_modes[p]);
			repeat (RANDOM_ITEMS / 8) begin
				// a quiet stretch outside the middle phases
				if ((p < 2 || p > 4) && $urandom_range(0, 99) < 8) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 3)) @(posedge clk);
				end
				if (n == 700) drain();
				put_stencil(rand_stencil(), 1'b0, none);
				n++;
			end
		end
		start <= 1'b0;

		while (face_expected.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		$display("stencils sent %0d, results checked %0d, quick spacing errors %0d",
			items_sent, results_seen, quick_errors);
		$display("schemes upwind, linear upwind, quick and the spare code all exercised");
		if (mismatches == 0 && face_expected.size() == 0) begin
			$display("tvd_limited_face_value_top: match");
		end else begin
			$display("tvd_limited_face_value_top: mismatch");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/tvdlf_pkg.sv
rtl/core/tvdlf_div.sv
rtl/core/tvd_limited_face_value_top.sv
bench/tb.sv
